FILE: rtl/tcdtt_pkg.sv
package tcdtt_pkg;

  localparam int FUNC_W  = 3;
  localparam int IDX_W   = 10;
  localparam int DEPTH_W = 8;
  localparam int GEN_W   = 16;
  localparam int STAT_W  = 2;
  localparam int TASK_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 3'd0,
    FN_RAISE  = 3'd1,
    FN_QUEUE  = 3'd2,
    FN_PROC   = 3'd3,
    FN_IDLE   = 3'd4,
    FN_RETIRE = 3'd5,
    FN_RESET  = 3'd6,
    FN_NOP    = 3'd7
  } func_t;

  typedef enum logic [TASK_W-1:0] {
    TS_IDLE    = 2'd0,
    TS_QUEUED  = 2'd1,
    TS_PROC    = 2'd2,
    TS_RETIRED = 2'd3
  } task_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_READ  = 3'd1,
    S_EXEC  = 3'd2,
    S_WALK  = 3'd3,
    S_SWEEP = 3'd4,
    S_FIN   = 3'd5
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic read;
    logic exec;
    logic walk;
    logic sweep;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_t func;
    logic  exec_walk;
    logic  walk_more;
    logic  used_zero;
    logic  sweep_last;
  } stat_t;

endpackage

FILE: rtl/tcdtt_ctrl.sv
module tcdtt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output tcdtt_pkg::cmd_t   cmd,
  input  tcdtt_pkg::stat_t  stat
);
  import tcdtt_pkg::*;

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        priority if (stat.exec_walk) state_nxt = S_WALK;
        else if (stat.func == FN_RESET && !stat.used_zero) state_nxt = S_SWEEP;
        else state_nxt = S_FIN;
      end
      S_WALK: begin
        if (!stat.walk_more) state_nxt = S_FIN;
      end
      S_SWEEP: begin
        if (stat.sweep_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    busy        = 1'b1;
    out_valid   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_READ:  cmd.read  = 1'b1;
      S_EXEC:  cmd.exec  = 1'b1;
      S_WALK:  cmd.walk  = 1'b1;
      S_SWEEP: cmd.sweep = 1'b1;
      S_FIN:   out_valid = 1'b1;
      default: busy = 1'b1;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_READ))
    else $error("accepted item did not start a table read");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command");
`endif

endmodule

FILE: rtl/tcdtt_datapath.sv
module tcdtt_datapath #(
  parameter int MAX_CELLS      = 1024,
  parameter int MAX_TREE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcdtt_pkg::cmd_t                   cmd,
  output tcdtt_pkg::stat_t                  stat,
  input  logic [tcdtt_pkg::FUNC_W-1:0]      in_func,
  input  logic [tcdtt_pkg::IDX_W-1:0]       in_cell_index,
  input  logic [tcdtt_pkg::IDX_W-1:0]       in_parent_cell,
  input  logic                              in_has_parent,
  input  logic [tcdtt_pkg::DEPTH_W-1:0]     in_depth_value,
  output logic [tcdtt_pkg::STAT_W-1:0]      res_status,
  output logic                              res_changed,
  output logic [tcdtt_pkg::IDX_W-1:0]       res_new_cell,
  output logic [tcdtt_pkg::DEPTH_W-1:0]     res_depth,
  output logic [tcdtt_pkg::TASK_W-1:0]      res_state,
  output logic [tcdtt_pkg::GEN_W-1:0]       res_gen
);
  import tcdtt_pkg::*;

  localparam int AW    = $clog2(MAX_CELLS);
  localparam int CNTW  = $clog2(MAX_CELLS + 1);
  localparam int CMPW  = (CNTW > IDX_W) ? CNTW : IDX_W;
  localparam int LVW   = $clog2(MAX_TREE_DEPTH + 1);
  localparam int LINKW = AW + 1;

  // cell tables, undefined until the cell is appended
  logic [LINKW-1:0]   link_mem  [MAX_CELLS];
  logic [DEPTH_W-1:0] depth_mem [MAX_CELLS];
  task_t              state_mem [MAX_CELLS];
  logic [GEN_W-1:0]   gen_mem   [MAX_CELLS];

  func_t              func_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   par_r;
  logic               hasp_r;
  logic [DEPTH_W-1:0] dval_r;

  logic [CNTW-1:0]    used_r,  used_nxt;
  logic [AW-1:0]      cur_r,   cur_nxt;
  logic [LVW-1:0]     level_r, level_nxt;
  logic [AW-1:0]      sweep_r, sweep_nxt;

  logic [LINKW-1:0]   link_rd_r;
  logic [DEPTH_W-1:0] depth_rd_r;
  task_t              state_rd_r;
  logic [GEN_W-1:0]   gen_rd_r;

  status_t            res_status_r,  res_status_nxt;
  logic               res_changed_r, res_changed_nxt;
  logic [IDX_W-1:0]   res_new_r,     res_new_nxt;
  logic [DEPTH_W-1:0] res_depth_r,   res_depth_nxt;
  task_t              res_state_r,   res_state_nxt;
  logic [GEN_W-1:0]   res_gen_r,     res_gen_nxt;

  logic [CMPW-1:0]    used_x, idx_x, par_x, cur_x, sweep_x;
  logic [AW-1:0]      idx_a, par_a, new_a;
  logic               full, bad_par, idx_ok;
  logic               link_v;
  logic [AW-1:0]      link_up;
  logic               raise_hit, walk_hit, last_level;
  logic               exec_walk, walk_more, sweep_last;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               we_link, we_depth, we_state, we_gen;
  logic [LINKW-1:0]   wr_link;
  logic [DEPTH_W-1:0] wr_depth;
  task_t              wr_state;
  logic [GEN_W-1:0]   wr_gen;

  assign used_x  = CMPW'(used_r);
  assign idx_x   = CMPW'(idx_r);
  assign par_x   = CMPW'(par_r);
  assign cur_x   = CMPW'(cur_r);
  assign sweep_x = CMPW'(sweep_r);
  assign idx_a   = idx_x[AW-1:0];
  assign par_a   = par_x[AW-1:0];
  assign new_a   = used_x[AW-1:0];

  assign full    = (used_x == CMPW'(MAX_CELLS));
  assign bad_par = hasp_r && (par_x >= used_x);
  assign idx_ok  = (idx_x < used_x);

  assign link_v  = link_rd_r[AW];
  assign link_up = link_rd_r[AW-1:0];

  assign raise_hit  = (depth_rd_r < dval_r);
  assign walk_hit   = (cur_x < used_x) && raise_hit;
  assign last_level = (level_r >= LVW'(MAX_TREE_DEPTH - 1));
  assign exec_walk  = (func_r == FN_RAISE) && idx_ok && raise_hit && link_v;
  assign walk_more  = walk_hit && link_v && !last_level;
  assign sweep_last = ((sweep_x + CMPW'(1)) == used_x);

  assign stat.func       = func_r;
  assign stat.exec_walk  = exec_walk;
  assign stat.walk_more  = walk_more;
  assign stat.used_zero  = (used_r == '0);
  assign stat.sweep_last = sweep_last;

  // read port: addressed cell first, then each parent up the chain
  assign rd_en   = cmd.read || cmd.exec || cmd.walk;
  assign rd_addr = cmd.read ? idx_a : link_up;

  always_comb begin
    wr_addr  = idx_a;
    we_link  = 1'b0;
    we_depth = 1'b0;
    we_state = 1'b0;
    we_gen   = 1'b0;
    wr_link  = '0;
    wr_depth = dval_r;
    wr_state = TS_IDLE;
    wr_gen   = gen_rd_r + GEN_W'(1);
    used_nxt = used_r;

    res_status_nxt  = res_status_r;
    res_changed_nxt = res_changed_r;
    res_new_nxt     = res_new_r;
    res_depth_nxt   = res_depth_r;
    res_state_nxt   = res_state_r;
    res_gen_nxt     = res_gen_r;

    priority if (cmd.exec) begin
      res_status_nxt  = STAT_OK;
      res_changed_nxt = 1'b0;
      res_new_nxt     = '0;
      res_depth_nxt   = '0;
      res_state_nxt   = TS_IDLE;
      res_gen_nxt     = '0;
      unique case (func_r)
        FN_APPEND: begin
          priority if (full) begin
            res_status_nxt = STAT_FULL;
          end else if (bad_par) begin
            res_status_nxt = STAT_RANGE;
          end else begin
            wr_addr     = new_a;
            we_link     = 1'b1;
            we_depth    = 1'b1;
            we_state    = 1'b1;
            we_gen      = 1'b1;
            wr_link     = hasp_r ? {1'b1, par_a} : '0;
            wr_depth    = '0;
            wr_state    = TS_IDLE;
            wr_gen      = '0;
            used_nxt    = used_r + CNTW'(1);
            res_new_nxt = used_x[IDX_W-1:0];
          end
        end
        FN_RESET, FN_NOP: begin
          if (idx_ok) begin
            res_depth_nxt = depth_rd_r;
            res_gen_nxt   = gen_rd_r;
            res_state_nxt = (func_r == FN_RESET) ? TS_IDLE : state_rd_r;
          end
        end
        default: begin
          if (!idx_ok) begin
            res_status_nxt = STAT_RANGE;
          end else begin
            res_depth_nxt = depth_rd_r;
            res_state_nxt = state_rd_r;
            res_gen_nxt   = gen_rd_r;
            unique case (func_r)
              FN_RAISE: begin
                if (raise_hit) begin
                  we_depth        = 1'b1;
                  res_depth_nxt   = dval_r;
                  res_changed_nxt = 1'b1;
                end
              end
              FN_QUEUE: begin
                if (state_rd_r != TS_QUEUED && state_rd_r != TS_PROC) begin
                  we_state        = 1'b1;
                  we_gen          = 1'b1;
                  wr_state        = TS_QUEUED;
                  res_state_nxt   = TS_QUEUED;
                  res_gen_nxt     = wr_gen;
                  res_changed_nxt = 1'b1;
                end
              end
              FN_PROC: begin
                if (state_rd_r == TS_QUEUED) begin
                  we_state        = 1'b1;
                  wr_state        = TS_PROC;
                  res_state_nxt   = TS_PROC;
                  res_changed_nxt = 1'b1;
                end
              end
              FN_IDLE: begin
                we_state        = 1'b1;
                wr_state        = TS_IDLE;
                res_state_nxt   = TS_IDLE;
                res_changed_nxt = 1'b1;
              end
              FN_RETIRE: begin
                we_state        = 1'b1;
                wr_state        = TS_RETIRED;
                res_state_nxt   = TS_RETIRED;
                res_changed_nxt = 1'b1;
              end
              default: begin
                res_changed_nxt = 1'b0;
              end
            endcase
          end
        end
      endcase
    end else if (cmd.walk) begin
      // ancestor shallower than the new depth: lift it
      wr_addr  = cur_r;
      we_depth = walk_hit;
    end else if (cmd.sweep) begin
      wr_addr  = sweep_r;
      we_state = 1'b1;
      wr_state = TS_IDLE;
    end else begin
      we_link = 1'b0;
    end
  end

  always_comb begin
    cur_nxt   = cur_r;
    level_nxt = level_r;
    sweep_nxt = sweep_r;
    if ((cmd.exec && exec_walk) || (cmd.walk && walk_more)) cur_nxt = link_up;
    if (cmd.exec) begin
      level_nxt = '0;
      sweep_nxt = '0;
    end
    if (cmd.walk && walk_more) level_nxt = level_r + LVW'(1);
    if (cmd.sweep) sweep_nxt = sweep_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func_t'(in_func);
      idx_r  <= in_cell_index;
      par_r  <= in_parent_cell;
      hasp_r <= in_has_parent;
      dval_r <= in_depth_value;
    end
    cur_r         <= cur_nxt;
    level_r       <= level_nxt;
    sweep_r       <= sweep_nxt;
    res_status_r  <= res_status_nxt;
    res_changed_r <= res_changed_nxt;
    res_new_r     <= res_new_nxt;
    res_depth_r   <= res_depth_nxt;
    res_state_r   <= res_state_nxt;
    res_gen_r     <= res_gen_nxt;
  end

  always_ff @(posedge clk) begin
    if (we_link)  link_mem[wr_addr]  <= wr_link;
    if (we_depth) depth_mem[wr_addr] <= wr_depth;
    if (we_state) state_mem[wr_addr] <= wr_state;
    if (we_gen)   gen_mem[wr_addr]   <= wr_gen;
    if (rd_en) begin
      link_rd_r  <= link_mem[rd_addr];
      depth_rd_r <= depth_mem[rd_addr];
      state_rd_r <= state_mem[rd_addr];
      gen_rd_r   <= gen_mem[rd_addr];
    end
  end

  assign res_status   = res_status_r;
  assign res_changed  = res_changed_r;
  assign res_new_cell = res_new_r;
  assign res_depth    = res_depth_r;
  assign res_state    = res_state_r;
  assign res_gen      = res_gen_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNTW'(MAX_CELLS))
    else $error("cell count above table size");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (used_r != $past(used_r)))
      |-> ((used_r == $past(used_r) + CNTW'(1)) && $past(cmd.exec)))
    else $error("cell count moved other than by one append");

  a_walk_level: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> (level_r < LVW'(MAX_TREE_DEPTH)))
    else $error("ancestor walk past depth limit");
`endif

endmodule

FILE: rtl/tree_cell_depth_and_task_table.sv
// Tree cell depth and task table.
//
// Input channel: present in_func and its operands with start high; the item
// is taken at the rising edge where start is high and busy is low. busy stays
// high until the result has been shown.
// Result channel: out_valid is high for exactly one cycle with out_status,
// out_changed, out_new_cell, out_depth_now, out_state_now and
// out_generation_now. The receiver cannot stall; the result must be taken
// in that cycle.
// Sequence for append, marks and unused codes: table read, execute, result;
// busy keeps the next item out until that result has been shown.
// A raise adds a walk step per ancestor visited, the one that stops the walk
// included, at most MAX_TREE_DEPTH: one table read and up to one write per
// level. A reset-all sweeps the state table one cell per cycle, over every
// cell in use.
// Reset (rst_n low, synchronous) empties the table and returns to idle; the
// per-cell tables themselves are not cleared.
module tree_cell_depth_and_task_table #(
  parameter int MAX_CELLS      = 1024,
  parameter int MAX_TREE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [tcdtt_pkg::FUNC_W-1:0]      in_func,
  input  logic [tcdtt_pkg::IDX_W-1:0]       in_cell_index,
  input  logic [tcdtt_pkg::IDX_W-1:0]       in_parent_cell,
  input  logic                              in_has_parent,
  input  logic [tcdtt_pkg::DEPTH_W-1:0]     in_depth_value,
  output logic                              out_valid,
  output logic [tcdtt_pkg::STAT_W-1:0]      out_status,
  output logic                              out_changed,
  output logic [tcdtt_pkg::IDX_W-1:0]       out_new_cell,
  output logic [tcdtt_pkg::DEPTH_W-1:0]     out_depth_now,
  output logic [tcdtt_pkg::TASK_W-1:0]      out_state_now,
  output logic [tcdtt_pkg::GEN_W-1:0]       out_generation_now
);
  import tcdtt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing: idle, read, execute, walk or sweep, result
  tcdtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // cell tables, cell count and result registers
  tcdtt_datapath #(
    .MAX_CELLS      (MAX_CELLS),
    .MAX_TREE_DEPTH (MAX_TREE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_func        (in_func),
    .in_cell_index  (in_cell_index),
    .in_parent_cell (in_parent_cell),
    .in_has_parent  (in_has_parent),
    .in_depth_value (in_depth_value),
    .res_status     (out_status),
    .res_changed    (out_changed),
    .res_new_cell   (out_new_cell),
    .res_depth      (out_depth_now),
    .res_state      (out_state_now),
    .res_gen        (out_generation_now)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import tcdtt_pkg::*;

  localparam int MAX_CELLS      = 1024;
  localparam int MAX_TREE_DEPTH = 16;
  // worst result latency: a reset-all sweep over a full table plus the pipe
  localparam int SETTLE_CYCLES  = MAX_CELLS + MAX_TREE_DEPTH + 16;

  // one request as the driver presents it, plus pacing hints
  typedef struct {
    func_t                func;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     parent;
    logic                 has_parent;
    logic [DEPTH_W-1:0]   depth;
    int                   idle_pct;   // chance per cycle that the sender holds off
    bit                   drain;      // hold until every result is back
  } request_t;

  // one result as the table should report it
  typedef struct {
    int                   seq;
    status_t              status;
    logic                 changed;
    logic [IDX_W-1:0]     new_cell;
    logic [DEPTH_W-1:0]   depth;
    task_t                state;
    logic [GEN_W-1:0]     gen;
  } outcome_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0]  in_func        = '0;
  logic [IDX_W-1:0]   in_cell_index  = '0;
  logic [IDX_W-1:0]   in_parent_cell = '0;
  logic               in_has_parent  = 1'b0;
  logic [DEPTH_W-1:0] in_depth_value = '0;
  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic               out_changed;
  logic [IDX_W-1:0]   out_new_cell;
  logic [DEPTH_W-1:0] out_depth_now;
  logic [TASK_W-1:0]  out_state_now;
  logic [GEN_W-1:0]   out_generation_now;

  always #5 clk = ~clk;

  tree_cell_depth_and_task_table #(
    .MAX_CELLS      (MAX_CELLS),
    .MAX_TREE_DEPTH (MAX_TREE_DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_cell_index      (in_cell_index),
    .in_parent_cell     (in_parent_cell),
    .in_has_parent      (in_has_parent),
    .in_depth_value     (in_depth_value),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_changed        (out_changed),
    .out_new_cell       (out_new_cell),
    .out_depth_now      (out_depth_now),
    .out_state_now      (out_state_now),
    .out_generation_now (out_generation_now)
  );

  request_t requests_waiting[$];   // built up front, drained by the driver
  outcome_t outcomes_due[$];       // predicted results, oldest first
  request_t cur;                   // item on the input ports right now
  bit       item_taken = 1'b0;     // set at the edge that accepts cur
  int       accepted_count = 0;
  int       mismatches = 0;
  longint   cycle_count = 0;
  longint   run_limit = 64'd1_000_000_000;

  // ---------------------------------------------------------------------
  // Shadow copy of the cell table. Updated in accept order, so each
  // prediction sees the table exactly as the block will when it runs.
  // ---------------------------------------------------------------------
  logic               link_valid [MAX_CELLS];
  logic [IDX_W-1:0]   link_up    [MAX_CELLS];
  logic [DEPTH_W-1:0] depth_tab  [MAX_CELLS];
  task_t              state_tab  [MAX_CELLS];
  logic [GEN_W-1:0]   gen_tab    [MAX_CELLS];
  int                 cells_in_use = 0;

  function automatic outcome_t table_outcome(request_t r);
    outcome_t o;
    bit       show;
    int       i;
    int       lvl;
    int       here;
    int       up;
    o.seq      = accepted_count;
    o.status   = STAT_OK;
    o.changed  = 1'b0;
    o.new_cell = '0;
    o.depth    = '0;
    o.state    = TS_IDLE;
    o.gen      = '0;
    show       = 1'b0;
    case (r.func)
      FN_APPEND: begin
        if (cells_in_use >= MAX_CELLS) begin
          o.status = STAT_FULL;
        end else if (r.has_parent && r.parent >= cells_in_use) begin
          // parent must already exist, which also rules out loops
          o.status = STAT_RANGE;
        end else begin
          link_valid[cells_in_use] = r.has_parent;
          link_up[cells_in_use]    = r.parent;
          depth_tab[cells_in_use]  = '0;
          state_tab[cells_in_use]  = TS_IDLE;
          gen_tab[cells_in_use]    = '0;
          o.new_cell   = cells_in_use[IDX_W-1:0];
          cells_in_use = cells_in_use + 1;
        end
      end
      FN_RESET: begin
        for (i = 0; i < cells_in_use; i++) state_tab[i] = TS_IDLE;
        show = (r.idx < cells_in_use);
      end
      FN_NOP: begin
        show = (r.idx < cells_in_use);
      end
      default: begin
        if (r.idx >= cells_in_use) begin
          o.status = STAT_RANGE;
        end else begin
          show = 1'b1;
          case (r.func)
            FN_RAISE: begin
              if (depth_tab[r.idx] < r.depth) begin
                depth_tab[r.idx] = r.depth;
                o.changed = 1'b1;
                // lift ancestors, at most MAX_TREE_DEPTH of them
                here = r.idx;
                for (lvl = 0; lvl < MAX_TREE_DEPTH; lvl++) begin
                  if (!link_valid[here]) break;
                  up = link_up[here];
                  if (up >= cells_in_use) break;
                  if (depth_tab[up] >= r.depth) break;
                  depth_tab[up] = r.depth;
                  here = up;
                end
              end
            end
            FN_QUEUE: begin
              if (state_tab[r.idx] != TS_QUEUED && state_tab[r.idx] != TS_PROC) begin
                state_tab[r.idx] = TS_QUEUED;
                gen_tab[r.idx]   = gen_tab[r.idx] + 1'b1;  // wraps at 16 bits
                o.changed = 1'b1;
              end
            end
            FN_PROC: begin
              if (state_tab[r.idx] == TS_QUEUED) begin
                state_tab[r.idx] = TS_PROC;
                o.changed = 1'b1;
              end
            end
            FN_IDLE: begin
              state_tab[r.idx] = TS_IDLE;
              o.changed = 1'b1;
            end
            default: begin
              state_tab[r.idx] = TS_RETIRED;
              o.changed = 1'b1;
            end
          endcase
        end
      end
    endcase
    if (show) begin
      o.depth = depth_tab[r.idx];
      o.state = state_tab[r.idx];
      o.gen   = gen_tab[r.idx];
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus building. gen_cells tracks how many cells the queued appends
  // will have created, so sequences can aim at cells that will exist.
  // ---------------------------------------------------------------------
  int gen_cells  = 0;
  int phase_idle = 0;
  bit drain_next = 1'b0;

  task automatic add_req(func_t f, int idx, int parent, bit has_p, int depth);
    request_t r;
    r.func       = f;
    r.idx        = idx[IDX_W-1:0];
    r.parent     = parent[IDX_W-1:0];
    r.has_parent = has_p;
    r.depth      = depth[DEPTH_W-1:0];
    r.idle_pct   = phase_idle;
    r.drain      = drain_next;
    drain_next   = 1'b0;
    if (f == FN_APPEND && gen_cells < MAX_CELLS && (!has_p || parent < gen_cells))
      gen_cells++;
    requests_waiting.insert(requests_waiting.size(), r);
  endtask

  // Mostly well-formed sequences on live cells, some raw noise.
  task automatic random_traffic(int n_items);
    int base;
    int kind;
    int c;
    int k;
    int i;
    base = requests_waiting.size();
    while (requests_waiting.size() - base < n_items) begin
      kind = $urandom_range(99);
      c    = $urandom_range(gen_cells - 1);
      if (kind < 25) begin
        // task life cycle: queue, usually process, then finish somehow
        add_req(FN_QUEUE, c, $urandom_range(1023), $urandom_range(1), $urandom_range(255));
        if ($urandom_range(3) != 0)
          add_req(FN_PROC, c, $urandom_range(1023), $urandom_range(1), $urandom_range(255));
        case ($urandom_range(2))
          0:       add_req(FN_IDLE, c, $urandom_range(1023), 1'b0, $urandom_range(255));
          1:       add_req(FN_RETIRE, c, $urandom_range(1023), 1'b1, $urandom_range(255));
          default: add_req(FN_QUEUE, c, $urandom_range(1023), 1'b0, $urandom_range(255));
        endcase
      end else if (kind < 45) begin
        // grow a branch below c, then raise its tip so the walk climbs it
        k = $urandom_range(6, 1);
        for (i = 0; i < k; i++)
          add_req(FN_APPEND, $urandom_range(1023), (i == 0) ? c : gen_cells - 1, 1'b1,
                  $urandom_range(255));
        add_req(FN_RAISE, gen_cells - 1, $urandom_range(1023), $urandom_range(1),
                $urandom_range(255));
      end else if (kind < 65) begin
        add_req(FN_RAISE, c, $urandom_range(1023), $urandom_range(1), $urandom_range(255));
      end else if (kind < 85) begin
        add_req(func_t'($urandom_range(FN_RETIRE, FN_QUEUE)), c, $urandom_range(1023),
                $urandom_range(1), $urandom_range(255));
      end else if (kind < 88) begin
        add_req(FN_RESET, $urandom_range(1023), $urandom_range(1023), $urandom_range(1),
                $urandom_range(255));
      end else begin
        // raw noise: any code, any index, any parent
        add_req(func_t'($urandom_range(7)), $urandom_range(1023), $urandom_range(1023),
                $urandom_range(1), $urandom_range(255));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: changes inputs on the falling edge. start stays up until the
  // item is taken; afterwards the next item may follow at once.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      item_taken = 1'b0;
      if (requests_waiting.size() == 0) begin
        start <= 1'b0;
      end else if (requests_waiting[0].drain && outcomes_due.size() != 0) begin
        start <= 1'b0;
      end else if ($urandom_range(99) < requests_waiting[0].idle_pct) begin
        start <= 1'b0;
      end else begin
        cur = requests_waiting.pop_front();
        in_func        <= cur.func;
        in_cell_index  <= cur.idx;
        in_parent_cell <= cur.parent;
        in_has_parent  <= cur.has_parent;
        in_depth_value <= cur.depth;
        start          <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks the result strobe first, then records an accepted item.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    outcome_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (outcomes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with no item outstanding: st=%0d ch=%0d new=%0d dep=%0d",
                     out_status, out_changed, out_new_cell, out_depth_now);
        end else begin
          want = outcomes_due.pop_front();
          if (out_status !== want.status || out_changed !== want.changed ||
              out_new_cell !== want.new_cell || out_depth_now !== want.depth ||
              out_state_now !== want.state || out_generation_now !== want.gen) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("item %0d mismatch: expected st=%0d ch=%0d new=%0d dep=%0d task=%0d gen=%0d",
                       want.seq, want.status, want.changed, want.new_cell, want.depth,
                       want.state, want.gen);
              $display("item %0d            got st=%0d ch=%0d new=%0d dep=%0d task=%0d gen=%0d",
                       want.seq, out_status, out_changed, out_new_cell, out_depth_now,
                       out_state_now, out_generation_now);
            end
          end
        end
      end
      if (start && !busy) begin
        outcomes_due.insert(outcomes_due.size(), table_outcome(cur));
        accepted_count++;
        item_taken = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > run_limit) begin
      $display("FAIL tree_cell_depth_and_task_table");
      $finish;
    end
  end

  initial begin
    int i;
    int j;
    longint budget;

    // ---- directed: empty table, bad parent, deep chain, every code ----
    phase_idle = 0;
    add_req(FN_RAISE, 0, 0, 1'b0, 8'hFF);          // nothing exists yet
    add_req(FN_RESET, 0, 0, 1'b0, 0);              // reset-all on an empty table, no sweep
    add_req(FN_APPEND, 0, 0, 1'b1, 0);             // parent does not exist
    add_req(FN_APPEND, 1023, 1023, 1'b0, 255);     // root, cell 0
    for (i = 1; i < 18; i++)
      add_req(FN_APPEND, 0, i - 1, 1'b1, 0);       // chain 1..17
    add_req(FN_RAISE, 17, 0, 1'b0, 255);           // walk stops after 16 levels
    add_req(FN_NOP, 0, 0, 1'b0, 0);                // root must be left alone
    add_req(FN_RAISE, 17, 0, 1'b0, 200);           // not higher
    add_req(FN_RAISE, 3, 0, 1'b0, 0);              // depth zero, not higher
    add_req(FN_QUEUE, 17, 0, 1'b0, 0);
    add_req(FN_QUEUE, 17, 0, 1'b0, 0);             // already queued
    add_req(FN_PROC, 17, 0, 1'b0, 0);
    add_req(FN_RETIRE, 17, 0, 1'b0, 0);
    add_req(FN_QUEUE, 17, 0, 1'b0, 0);             // requeue from retired
    add_req(FN_IDLE, 17, 0, 1'b0, 0);
    add_req(FN_RESET, 1023, 0, 1'b0, 0);           // addressed cell absent
    add_req(FN_NOP, 1023, 1023, 1'b1, 255);
    add_req(FN_PROC, 1023, 0, 1'b0, 0);            // index out of range

    // ---- random phases: no idling, heavy sender idling, light idling ----
    drain_next = 1'b1;
    random_traffic(250);
    phase_idle = 88;
    drain_next = 1'b1;
    random_traffic(250);
    phase_idle = 16;
    drain_next = 1'b1;
    random_traffic(250);

    // ---- fill the table, then hit it while full ----
    phase_idle = 0;
    drain_next = 1'b1;
    while (gen_cells < MAX_CELLS)
      add_req(FN_APPEND, $urandom_range(1023),
              ($urandom_range(15) == 0) ? $urandom_range(1023) : $urandom_range(gen_cells - 1),
              $urandom_range(3) != 0, $urandom_range(255));
    for (i = 0; i < 4; i++)
      add_req(FN_APPEND, $urandom_range(1023), $urandom_range(1023), $urandom_range(1),
              $urandom_range(255));
    phase_idle = 16;
    random_traffic(60);

    // budget: every item at its slowest, plus sender gaps, several times over
    budget = 0;
    for (j = 0; j < requests_waiting.size(); j++)
      budget += 8 + MAX_TREE_DEPTH
              + ((requests_waiting[j].func == FN_RESET) ? MAX_CELLS : 0)
              + ((requests_waiting[j].idle_pct != 0) ? 100 : 0);
    run_limit = budget * 4 + 20000;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    while (requests_waiting.size() != 0 || start || outcomes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("PASS tree_cell_depth_and_task_table");
    else
      $display("FAIL tree_cell_depth_and_task_table");
    $finish;
  end

endmodule
